>>> sv/assert_macros.svh
// Assertion macros for the RTL files; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rvb_pkg.sv
// Types and register codes of the radial vignette blend.
`default_nettype none

package rvb_pkg;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 40;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_START_RADIUS = 3'd2,
    CFG_FALLOFF_SQ   = 3'd3,
    CFG_MAX_BLEND    = 3'd4,
    CFG_TINT_RED     = 3'd5,
    CFG_TINT_GREEN   = 3'd6,
    CFG_TINT_BLUE    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] pix_x;
    logic [11:0] pix_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       was_tinted;
  } pix_out_t;

endpackage

`default_nettype wire

>>> sv/radial_vignette_blend_top.sv
// Radial vignette blend: six-stage pixel pipeline with its configuration registers.
//
//   channel   direction  handshake                 payload
//   pixel in  input      start high, busy low      in_i (pix_in_t)
//   result    output     result_valid_o, 1 cycle   out_o (pix_out_t)
//   config    input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One pixel enters every cycle; its result word passes through the stages below and is on
// the ports while result_valid_o is high.
// Stages: offsets, squares, excess distance, weight products, weight, blend.
// The latency is fixed by the two 29x20 weight multiplies and the blend multiplies.
// Reset clears the stage valid bits and loads the register reset values.
// There is no back-pressure: busy stays low and results are never held.
`default_nettype none
`include "assert_macros.svh"

module radial_vignette_blend_top
  import rvb_pkg::*;
#(
  parameter int unsigned COORD_BITS       = 12,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire pix_in_t                in_i,
  output logic                        result_valid_o,
  output pix_out_t                    out_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i
);

  localparam int unsigned WB     = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned WShift = 40 - WEIGHT_FRAC_BITS;
  localparam int unsigned Lat    = 6;
  localparam logic [11:0] CoordMask =
    (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);
  localparam logic [50:0] WOneL = 51'(1) << WEIGHT_FRAC_BITS;
  localparam logic [WB-1:0] WOneW = WOneL[WB-1:0];

  // Configuration registers
  logic signed [13:0] center_x_q, center_y_q;
  logic [11:0]        start_radius_q;
  logic [39:0]        falloff_q;
  logic [16:0]        max_blend_q;
  logic [7:0]         tint_r_q, tint_g_q, tint_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      start_radius_q <= '0;
      falloff_q      <= '0;
      max_blend_q    <= 17'd49152;
      tint_r_q       <= '0;
      tint_g_q       <= '0;
      tint_b_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:     center_x_q     <= signed'(cfg_wdata_i[13:0]);
        CFG_CENTER_Y:     center_y_q     <= signed'(cfg_wdata_i[13:0]);
        CFG_START_RADIUS: start_radius_q <= cfg_wdata_i[11:0];
        CFG_FALLOFF_SQ:   falloff_q      <= cfg_wdata_i[39:0];
        CFG_MAX_BLEND:    max_blend_q    <= cfg_wdata_i[16:0];
        CFG_TINT_RED:     tint_r_q       <= cfg_wdata_i[7:0];
        CFG_TINT_GREEN:   tint_g_q       <= cfg_wdata_i[7:0];
        CFG_TINT_BLUE:    tint_b_q       <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits of stages one to five, then the result strobe
  logic [4:0] vld_q;
  logic       res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[3:0], accept};
      res_vld_q <= vld_q[4];
    end
  end

  // Colour travels alongside the arithmetic
  logic [23:0] rgb_q [5];

  always_ff @(posedge clk_i) begin
    rgb_q[0] <= {in_i.red_in, in_i.green_in, in_i.blue_in};
    for (int i = 1; i < 5; i++) begin
      rgb_q[i] <= rgb_q[i-1];
    end
  end

  // Stage 1: offsets from the centre
  logic signed [14:0] px, py, dx_d, dy_d, dx_q, dy_q;

  assign px   = signed'({3'b000, in_i.pix_x & CoordMask});
  assign py   = signed'({3'b000, in_i.pix_y & CoordMask});
  assign dx_d = 15'(center_x_q) - px;
  assign dy_d = 15'(center_y_q) - py;

  // Stage 2: squares
  logic signed [29:0] sqx_full, sqy_full;
  logic [23:0]        rr_d;
  logic [27:0]        sqx_q, sqy_q;
  logic [23:0]        rr_q;

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign rr_d     = start_radius_q * start_radius_q;

  // Stage 3: excess squared distance, positive means outside the radius
  logic signed [29:0] dist_d;
  logic               tint_d;
  logic [28:0]        dist_q;
  logic               tnt3_q, tnt4_q, tnt5_q;

  assign dist_d = signed'(30'(sqx_q)) + signed'(30'(sqy_q)) - signed'(30'(rr_q));
  assign tint_d = !dist_d[29] && (dist_d != '0);

  // Stage 4: split weight product on the coefficient halves
  logic [48:0] ph_d, pl_d, ph_q, pl_q;

  assign ph_d = dist_q * falloff_q[39:20];
  assign pl_d = dist_q * falloff_q[19:0];

  // Stage 5: weight, saturated at the limit, clamped to one
  logic        big;
  logic [50:0] wsum, wsh, mb_ext, lim, wsat;
  logic [WB-1:0] w_d, w_q;

  assign big    = |ph_q[48:WShift-2];
  assign wsum   = {1'b0, ph_q[29:0], 20'b0} + {2'b00, pl_q};
  assign wsh    = wsum >> WShift;
  assign mb_ext = 51'(max_blend_q);
  assign lim    = (mb_ext > WOneL) ? WOneL : mb_ext;
  assign wsat   = (big || (wsh > lim)) ? lim : wsh;
  assign w_d    = tnt4_q ? wsat[WB-1:0] : '0;

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sqx_q  <= sqx_full[27:0];
    sqy_q  <= sqy_full[27:0];
    rr_q   <= rr_d;
    dist_q <= dist_d[28:0];
    tnt3_q <= tint_d;
    ph_q   <= ph_d;
    pl_q   <= pl_d;
    tnt4_q <= tnt3_q;
    w_q    <= w_d;
    tnt5_q <= tnt4_q;
  end

  // Stage 6: blend toward the tint; a zero weight returns the source exactly
  function automatic logic [7:0] mix_ch(input logic [WB-1:0] w, input logic [7:0] src,
                                        input logic [7:0] tint);
    logic [WB+8:0] acc;
    acc = (WB+9)'(WOneW - w) * (WB+9)'(src) + (WB+9)'(w) * (WB+9)'(tint);
    return acc[WEIGHT_FRAC_BITS +: 8];
  endfunction

  pix_out_t out_d, out_q;

  always_comb begin
    out_d.red_out    = mix_ch(w_q, rgb_q[4][23:16], tint_r_q);
    out_d.green_out  = mix_ch(w_q, rgb_q[4][15:8],  tint_g_q);
    out_d.blue_out   = mix_ch(w_q, rgb_q[4][7:0],   tint_b_q);
    out_d.was_tinted = tnt5_q;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = res_vld_q;
  assign out_o          = out_q;

  `ASSERT_IMPL(a_res_follows_accept, result_valid_o, $past(accept, Lat),
               "result without an accepted pixel")
  `ASSERT_IMPL(a_weight_le_one, vld_q[4], w_q <= WOneW, "blend weight above one")
  `ASSERT_IMPL(a_inside_passes, vld_q[4] && !tnt5_q, w_q == '0,
               "pixel inside radius carries a weight")
  `ASSERT_IMPL(a_untinted_unchanged, result_valid_o && !out_o.was_tinted,
               (out_o.red_out == $past(in_i.red_in, Lat)) &&
               (out_o.blue_out == $past(in_i.blue_in, Lat)),
               "untinted pixel changed")

endmodule

`default_nettype wire
